>>> src/jeoi_pkg.sv
// Package for the JPEG end-of-image checker: marker codes, parser phases,
// parser state and result types. Depends on nothing.
package jeoi_pkg;

   localparam logic [7:0] ByteFill     = 8'hFF;
   localparam logic [7:0] ByteZero     = 8'h00;
   localparam logic [7:0] MarkerEoi    = 8'hD9;
   localparam logic [7:0] MarkerSos    = 8'hDA;
   localparam logic [7:0] MarkerSoi    = 8'hD8;
   localparam logic [7:0] MarkerRstLo  = 8'hD0;
   localparam logic [7:0] MarkerRstHi  = 8'hD7;
   localparam logic [7:0] MarkerTem    = 8'h01;
   localparam logic [15:0] LenOverhead = 16'd2;

   typedef enum logic [8:0] {
      PH_SOI0    = 9'b000000001,
      PH_SOI1    = 9'b000000010,
      PH_EXPECT  = 9'b000000100,
      PH_FILL    = 9'b000001000,
      PH_LEN_HI  = 9'b000010000,
      PH_LEN_LO  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_SCAN    = 9'b010000000,
      PH_SCAN_FF = 9'b100000000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] skip_count;
      logic [7:0]  length_high;
      logic        segment_is_scan;
      logic        verdict_given;
   } state_type;

   typedef struct packed {
      logic valid;
      logic found;
   } result_type;

   localparam state_type StateReset = '{
      phase:           PH_SOI0,
      skip_count:      16'd0,
      length_high:     8'd0,
      segment_is_scan: 1'b0,
      verdict_given:   1'b0
   };

endpackage

>>> src/jpeg_eoi_marker_checker.sv
// Top level of the JPEG end-of-image checker: input register, parser state,
// result register. Depends on jeoi_pkg and jeoi_step.
//
// Usage:
//   Request channel (req_valid / req_stall): one codestream byte per request,
//   req_last set on the final byte of a stream. Streams follow each other
//   with no gap needed.
//   Result channel (rsp_valid / rsp_stall): at most one verdict per stream,
//   rsp_found = 1 for a genuine FF D9, 0 for a malformed or truncated stream.
//   Bytes after a verdict produce nothing until req_last, then the parser
//   rearms for the next stream.
// Path: a request accepted into the input register is parsed from there, and
//   its verdict, if any, is registered in the result register onto rsp_valid.
// Throughput: one byte per cycle unless a verdict waits under rsp_stall; the
//   parser state loop is a single compare/decrement step, so it limits nothing.
// Reset: synchronous, active high; clears both registers' valid flags and
//   puts the parser at the first SOI byte.
// Stall: while a verdict sits unaccepted and rsp_stall is high, the byte in
//   the input register waits, and req_stall rises only if that register is
//   occupied. Payloads hold under stall.
module jpeg_eoi_marker_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_found
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // parser state
   jeoi_pkg::state_type state_ff, state_in;
   jeoi_pkg::state_type step_state;
   jeoi_pkg::result_type step_res;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;

   logic advance;

   // Parse the held byte when the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   jeoi_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .next_state (step_state),
      .result     (step_res)
   );

   always_comb begin
      // hold the request while stalled, otherwise load the next one
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last;
      end

      // advance parser state only on a parsed byte
      state_in = advance ? step_state : state_ff;

      // drop a taken verdict, load a new one
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      if (advance && step_res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = step_res.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= jeoi_pkg::StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      in_last_ff   <= in_last_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   // A byte carrying last always rearms the parser.
   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=>
         (state_ff.phase == jeoi_pkg::PH_SOI0) && !state_ff.verdict_given)
      else $error("parser not rearmed after last byte");

   // No second verdict in one stream.
   a_one_verdict: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.verdict_given |-> !step_res.valid)
      else $error("verdict emitted twice in one stream");

   // A verdict before the end of the stream marks the stream as decided.
   a_verdict_marks: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.valid && !in_last_ff |=> state_ff.verdict_given)
      else $error("verdict not recorded");

   // Backpressure only when a verdict is blocked downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without cause");

   // A waiting verdict is not overwritten.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_found_ff))
      else $error("pending verdict lost");

endmodule

>>> src/jeoi_step.sv
// One parser step of the JPEG end-of-image checker: next state and optional
// verdict for one byte. Depends on jeoi_pkg.
module jeoi_step (
   input  jeoi_pkg::state_type  cur_state,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output jeoi_pkg::state_type  next_state,
   output jeoi_pkg::result_type result
);

   logic        is_fill;
   logic        is_eoi;
   logic        is_zero;
   logic        is_soi;
   logic        is_rst;
   logic        is_standalone;
   logic [15:0] seg_len;
   logic [15:0] skip_dec;
   logic        have_verdict;
   logic        verdict;
   jeoi_pkg::phase_type after_seg;

   assign is_fill       = (data_byte == jeoi_pkg::ByteFill);
   assign is_eoi        = (data_byte == jeoi_pkg::MarkerEoi);
   assign is_zero       = (data_byte == jeoi_pkg::ByteZero);
   assign is_soi        = (data_byte == jeoi_pkg::MarkerSoi);
   assign is_rst        = (data_byte >= jeoi_pkg::MarkerRstLo) &&
                          (data_byte <= jeoi_pkg::MarkerRstHi);
   assign is_standalone = is_rst || (data_byte == jeoi_pkg::MarkerTem);
   assign seg_len       = {cur_state.length_high, data_byte};
   assign skip_dec      = cur_state.skip_count - 16'd1;
   assign after_seg     = cur_state.segment_is_scan ? jeoi_pkg::PH_SCAN
                                                    : jeoi_pkg::PH_EXPECT;

   always_comb begin
      next_state   = cur_state;
      have_verdict = 1'b0;
      verdict      = 1'b0;
      result       = '0;

      if (cur_state.verdict_given) begin
         // swallow until the end of the stream, then rearm
         if (last) begin
            next_state = jeoi_pkg::StateReset;
         end
      end else begin
         case (cur_state.phase)
            jeoi_pkg::PH_SOI0: begin
               next_state.phase = jeoi_pkg::PH_SOI1;
            end
            jeoi_pkg::PH_SOI1: begin
               next_state.phase = jeoi_pkg::PH_EXPECT;
            end
            jeoi_pkg::PH_EXPECT: begin
               if (!is_fill) begin
                  have_verdict = 1'b1;
               end else begin
                  next_state.phase = jeoi_pkg::PH_FILL;
               end
            end
            jeoi_pkg::PH_FILL, jeoi_pkg::PH_SCAN_FF: begin
               if ((cur_state.phase == jeoi_pkg::PH_SCAN_FF) && (is_zero || is_rst)) begin
                  next_state.phase = jeoi_pkg::PH_SCAN;
               end else if (!is_fill) begin
                  // decode the marker code
                  if (is_eoi) begin
                     have_verdict = 1'b1;
                     verdict      = 1'b1;
                  end else if (is_zero || is_soi) begin
                     have_verdict = 1'b1;
                  end else if (is_standalone) begin
                     next_state.phase = jeoi_pkg::PH_EXPECT;
                  end else begin
                     next_state.segment_is_scan = (data_byte == jeoi_pkg::MarkerSos);
                     next_state.phase           = jeoi_pkg::PH_LEN_HI;
                  end
               end
            end
            jeoi_pkg::PH_LEN_HI: begin
               next_state.length_high = data_byte;
               next_state.phase       = jeoi_pkg::PH_LEN_LO;
            end
            jeoi_pkg::PH_LEN_LO: begin
               if (seg_len < jeoi_pkg::LenOverhead) begin
                  have_verdict = 1'b1;
               end else begin
                  next_state.skip_count = seg_len - jeoi_pkg::LenOverhead;
                  if (seg_len == jeoi_pkg::LenOverhead) begin
                     next_state.phase = after_seg;
                  end else begin
                     next_state.phase = jeoi_pkg::PH_PAYLOAD;
                  end
               end
            end
            jeoi_pkg::PH_PAYLOAD: begin
               next_state.skip_count = skip_dec;
               if (skip_dec == 16'd0) begin
                  next_state.phase = after_seg;
               end
            end
            jeoi_pkg::PH_SCAN: begin
               if (is_fill) begin
                  next_state.phase = jeoi_pkg::PH_SCAN_FF;
               end
            end
            default: begin
               next_state.phase = jeoi_pkg::PH_SOI1;
            end
         endcase

         // end of stream without a verdict counts as missing EOI
         if (last) begin
            have_verdict = 1'b1;
         end

         if (have_verdict) begin
            result.valid = 1'b1;
            result.found = verdict;
            if (last) begin
               next_state = jeoi_pkg::StateReset;
            end else begin
               next_state.verdict_given = 1'b1;
            end
         end
      end
   end

endmodule
